@@ rtl/xbt_pkg.sv @@
// Shared types, character codes and constants of the XML byte tokenizer.
package xbt_pkg;

   localparam int MAX_TAG_CHARS_DEF = 1023;
   localparam int LINE_WIDTH_DEF    = 24;
   localparam int QUEUE_DEPTH       = 4;
   localparam int LINE_NO_WIDTH     = 24;

   // result kinds
   localparam logic [2:0] KIND_TEXT      = 3'd0;
   localparam logic [2:0] KIND_NAME      = 3'd1;
   localparam logic [2:0] KIND_START_END = 3'd2;
   localparam logic [2:0] KIND_CLOSE_END = 3'd3;
   localparam logic [2:0] KIND_BAD_ENT   = 3'd4;
   localparam logic [2:0] KIND_END       = 3'd5;

   // characters
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;

   // packed entity names
   localparam logic [31:0] ENT_LT   = 32'h0000_6C74;
   localparam logic [31:0] ENT_GT   = 32'h0000_6774;
   localparam logic [31:0] ENT_QUOT = 32'h7175_6F74;
   localparam logic [31:0] ENT_APOS = 32'h6170_6F73;
   localparam logic [31:0] ENT_AMP  = 32'h0061_6D70;

   localparam logic [2:0] ENT_MAX_CHARS = 3'd4;
   localparam logic [2:0] ENT_TOO_LONG  = 3'd5;

   typedef enum logic [1:0] {
      MODE_TEXT,
      MODE_TAG_FIRST,
      MODE_TAG_BODY,
      MODE_ENTITY
   } mode_type;

   typedef struct packed {
      logic [2:0]               kind;
      logic [7:0]               value;
      logic [LINE_NO_WIDTH-1:0] line_no;
   } result_type;

   // one queue word: one or two results of one byte
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/xbt_front.sv @@
// Front end: accepts bytes, runs the scan state machine and forms result words.
module xbt_front #(
   parameter int MAX_TAG_CHARS = xbt_pkg::MAX_TAG_CHARS_DEF,
   parameter int LINE_WIDTH    = xbt_pkg::LINE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 in_byte,
   input  logic                       at_end,
   input  logic                       csr_write,
   input  logic                       csr_skip_blank,
   output logic                       push,
   output xbt_pkg::entry_type         push_entry
);
   import xbt_pkg::*;

   localparam int TLW = $clog2(MAX_TAG_CHARS + 1);

   mode_type              mode_ff, mode_in;
   logic [TLW-1:0]        tag_len_ff, tag_len_in;
   logic                  end_tag_ff, end_tag_in;
   logic                  hidden_ff, hidden_in;
   logic [31:0]           ent_code_ff, ent_code_in;
   logic [2:0]            ent_count_ff, ent_count_in;
   logic [LINE_WIDTH-1:0] line_ff, line_in;
   logic                  skip_ff;

   logic [LINE_WIDTH-1:0] line_inc;
   logic [31:0]           line_wide;
   logic [LINE_NO_WIDTH-1:0] line_out;
   logic                  ent_bad;
   logic [7:0]            ent_char;
   logic                  blank;
   logic                  hide_now;
   logic [1:0]            count;
   result_type            res0, res1;

   assign line_inc  = (line_ff == {LINE_WIDTH{1'b1}}) ? line_ff : line_ff + LINE_WIDTH'(1);
   assign line_wide = 32'(line_in);
   assign line_out  = line_wide[LINE_NO_WIDTH-1:0];

   assign blank = (in_byte == CH_SPACE) || (in_byte == CH_LF) ||
                  (in_byte == CH_CR) || (in_byte == CH_TAB);

   always_comb begin
      ent_bad  = 1'b0;
      ent_char = 8'd0;
      if (ent_count_ff > ENT_MAX_CHARS) begin
         ent_bad = 1'b1;
      end else begin
         case (ent_code_ff)
            ENT_LT:   ent_char = CH_LT;
            ENT_GT:   ent_char = CH_GT;
            ENT_QUOT: ent_char = CH_QUOT;
            ENT_APOS: ent_char = CH_APOS;
            ENT_AMP:  ent_char = CH_AMP;
            default:  ent_bad  = 1'b1;
         endcase
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      tag_len_in   = tag_len_ff;
      end_tag_in   = end_tag_ff;
      hidden_in    = hidden_ff;
      ent_code_in  = ent_code_ff;
      ent_count_in = ent_count_ff;
      line_in      = line_ff;
      hide_now     = 1'b0;
      count        = 2'd0;
      res0         = '0;
      res1         = '0;
      if (at_end) begin
         unique case (mode_ff)
            MODE_ENTITY: begin
               res0.kind  = ent_bad ? KIND_BAD_ENT : KIND_TEXT;
               res0.value = ent_char;
               count      = 2'd1;
            end
            MODE_TAG_FIRST, MODE_TAG_BODY: begin
               if (!hidden_ff) begin
                  res0.kind = end_tag_ff ? KIND_CLOSE_END : KIND_START_END;
                  count     = 2'd1;
               end
            end
            MODE_TEXT: ;
         endcase
         if (count == 2'd0) begin
            res0.kind = KIND_END;
         end else begin
            res1.kind = KIND_END;
         end
         count = count + 2'd1;
      end else begin
         unique case (mode_ff)
            MODE_ENTITY: begin
               if (in_byte == CH_SEMI) begin
                  res0.kind    = ent_bad ? KIND_BAD_ENT : KIND_TEXT;
                  res0.value   = ent_char;
                  count        = 2'd1;
                  mode_in      = MODE_TEXT;
                  ent_code_in  = '0;
                  ent_count_in = '0;
               end else if (ent_count_ff < ENT_MAX_CHARS) begin
                  ent_code_in  = {ent_code_ff[23:0], in_byte};
                  ent_count_in = ent_count_ff + 3'd1;
               end else begin
                  ent_code_in  = '0;
                  ent_count_in = ENT_TOO_LONG;
               end
            end
            MODE_TEXT: begin
               if (in_byte == CH_LT) begin
                  mode_in    = MODE_TAG_FIRST;
                  tag_len_in = '0;
                  end_tag_in = 1'b0;
                  hidden_in  = 1'b0;
               end else if (in_byte == CH_AMP) begin
                  mode_in      = MODE_ENTITY;
                  ent_code_in  = '0;
                  ent_count_in = '0;
               end else begin
                  if (in_byte == CH_LF) begin
                     line_in = line_inc;
                  end
                  if (!(skip_ff && blank)) begin
                     res0.kind  = KIND_TEXT;
                     res0.value = in_byte;
                     count      = 2'd1;
                  end
               end
            end
            MODE_TAG_FIRST, MODE_TAG_BODY: begin
               if (mode_ff == MODE_TAG_FIRST && in_byte == CH_SLASH) begin
                  end_tag_in = 1'b1;
                  mode_in    = MODE_TAG_BODY;
               end else begin
                  mode_in = MODE_TAG_BODY;
                  if (in_byte == CH_LF) begin
                     line_in = line_inc;
                  end
                  if (in_byte == CH_GT) begin
                     if (!hidden_ff) begin
                        res0.kind = end_tag_ff ? KIND_CLOSE_END : KIND_START_END;
                        count     = 2'd1;
                     end
                     mode_in    = MODE_TEXT;
                     tag_len_in = '0;
                     end_tag_in = 1'b0;
                     hidden_in  = 1'b0;
                  end else if (tag_len_ff < TLW'(MAX_TAG_CHARS)) begin
                     hide_now = hidden_ff;
                     if (tag_len_ff == '0) begin
                        hide_now = skip_ff && !end_tag_ff &&
                                   (in_byte == CH_BANG || in_byte == CH_QUEST);
                     end
                     hidden_in = hide_now;
                     if (!hide_now) begin
                        res0.kind  = KIND_NAME;
                        res0.value = in_byte;
                        count      = 2'd1;
                     end
                     tag_len_in = tag_len_ff + TLW'(1);
                  end
               end
            end
         endcase
      end
   end

   assign push              = accept && (count != 2'd0);
   assign push_entry.two    = count[1];
   // line number of the results is the count after this byte
   assign push_entry.first  = '{res0.kind, res0.value, line_out};
   assign push_entry.second = '{res1.kind, res1.value, line_out};

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b0;
      end else if (csr_write) begin
         skip_ff <= csr_skip_blank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && at_end)) begin
         mode_ff      <= MODE_TEXT;
         tag_len_ff   <= '0;
         end_tag_ff   <= 1'b0;
         hidden_ff    <= 1'b0;
         ent_code_ff  <= '0;
         ent_count_ff <= '0;
         line_ff      <= LINE_WIDTH'(1);
      end else if (accept) begin
         mode_ff      <= mode_in;
         tag_len_ff   <= tag_len_in;
         end_tag_ff   <= end_tag_in;
         hidden_ff    <= hidden_in;
         ent_code_ff  <= ent_code_in;
         ent_count_ff <= ent_count_in;
         line_ff      <= line_in;
      end
   end

endmodule

@@ rtl/xbt_queue.sv @@
// Short word queue between the front end and the output stage.
module xbt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  xbt_pkg::entry_type        push_entry,
   input  logic                      pop,
   output xbt_pkg::entry_type        head,
   output xbt_pkg::queue_status_type status
);
   import xbt_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       store_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   fill_ff;

   assign status.full  = (fill_ff == CW'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign head         = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + CW'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - CW'(1);
         end
      end
   end

endmodule

@@ rtl/xbt_back.sv @@
// Output stage: drains queue words one result at a time into the output register.
module xbt_back (
   input  logic                         clock,
   input  logic                         reset,
   input  xbt_pkg::entry_type           head,
   input  xbt_pkg::queue_status_type    status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_kind,
   output logic [7:0]                   rsp_value,
   output logic [xbt_pkg::LINE_NO_WIDTH-1:0] rsp_line_no,
   output logic                         rsp_last
);
   import xbt_pkg::*;

   logic       valid_ff, valid_in;
   logic       second_ff, second_in;
   result_type res_ff, res_in;
   logic       last_ff, last_in;
   logic       free;
   logic       load;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      pop       = 1'b0;
      load      = 1'b0;
      second_in = second_ff;
      res_in    = head.first;
      last_in   = 1'b1;
      if (free) begin
         if (second_ff) begin
            // second result of a two-result word
            load      = 1'b1;
            res_in    = head.second;
            pop       = 1'b1;
            second_in = 1'b0;
         end else if (!status.empty) begin
            load    = 1'b1;
            last_in = !head.two;
            if (head.two) begin
               second_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end
      end
      valid_in = load || (valid_ff && !free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= res_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_kind    = res_ff.kind;
   assign rsp_value   = res_ff.value;
   assign rsp_line_no = res_ff.line_no;
   assign rsp_last    = last_ff;

endmodule

@@ rtl/xml_byte_tokenizer.sv @@
// XML byte tokenizer: one byte a cycle while not stalled into text, tag-name and mark
// results, which pass through the queue and then the output register that drives rsp_valid.
// Throughput: one byte per cycle, bounded by the output register draining one result per
// cycle while rsp_stall is low; an end-of-stream byte in an entity or unhidden tag gives two.
// A four-word queue parts front and output; req_stall is high while it is full.
// Synchronous reset clears scan state, line count to 1, queue, output and skip_blank.
module xml_byte_tokenizer #(
   parameter int MAX_TAG_CHARS = xbt_pkg::MAX_TAG_CHARS_DEF,
   parameter int LINE_WIDTH    = xbt_pkg::LINE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_in_byte,
   input  logic                              req_at_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_kind,
   output logic [7:0]                        rsp_value,
   output logic [xbt_pkg::LINE_NO_WIDTH-1:0] rsp_line_no,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_skip_blank
);
   import xbt_pkg::*;

   logic             accept;
   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type status;

   assign req_stall = status.full;
   assign accept    = req_valid && !status.full;
   assign csr_ready = 1'b1;

   xbt_front #(
      .MAX_TAG_CHARS(MAX_TAG_CHARS),
      .LINE_WIDTH   (LINE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .at_end        (req_at_end),
      .csr_write     (csr_valid),
      .csr_skip_blank(csr_skip_blank),
      .push          (push),
      .push_entry    (push_entry)
   );

   xbt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   xbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .status     (status),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_kind   (rsp_kind),
      .rsp_value  (rsp_value),
      .rsp_line_no(rsp_line_no),
      .rsp_last   (rsp_last)
   );

endmodule
